>>> design/i2r_pkg.sv
package i2r_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] SYM_I = 3'd0;
   localparam logic [2:0] SYM_V = 3'd1;
   localparam logic [2:0] SYM_X = 3'd2;
   localparam logic [2:0] SYM_L = 3'd3;
   localparam logic [2:0] SYM_C = 3'd4;
   localparam logic [2:0] SYM_D = 3'd5;
   localparam logic [2:0] SYM_M = 3'd6;

   localparam logic [1:0] DEC_THOU = 2'd0;
   localparam logic [1:0] DEC_HUND = 2'd1;
   localparam logic [1:0] DEC_TENS = 2'd2;
   localparam logic [1:0] DEC_UNIT = 2'd3;

   typedef struct packed {
      logic [2:0] thou;
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] units;
   } digits_type;

   typedef struct packed {
      logic       valid;
      digits_type digits;
   } q_wr_type;

   typedef struct packed {
      logic       valid;
      digits_type digits;
   } q_rd_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_THOU,
      F_HUND,
      F_TENS
   } front_state_type;

   // symbols produced by one decimal digit
   function automatic logic [2:0] digit_len(input logic [1:0] dec, input logic [3:0] d);
      logic [2:0] len;
      len = 3'd0;
      if (dec == DEC_THOU) begin
         len = d[2:0];
      end else begin
         unique case (d)
            4'd0, 4'd1, 4'd2, 4'd3: len = d[2:0];
            4'd4, 4'd9:             len = 3'd2;
            4'd5, 4'd6, 4'd7, 4'd8: len = 3'(d - 4'd4);
            default:                len = 3'd0;
         endcase
      end
      return len;
   endfunction

   function automatic logic [2:0] digit_sym(input logic [1:0] dec, input logic [3:0] d,
                                            input logic [1:0] k);
      logic [2:0] one;
      logic [2:0] five;
      logic [2:0] ten;
      logic [2:0] sym;
      unique case (dec)
         DEC_THOU: begin one = SYM_M; five = SYM_M; ten = SYM_M; end
         DEC_HUND: begin one = SYM_C; five = SYM_D; ten = SYM_M; end
         DEC_TENS: begin one = SYM_X; five = SYM_L; ten = SYM_C; end
         default:  begin one = SYM_I; five = SYM_V; ten = SYM_X; end
      endcase
      if (dec == DEC_THOU) begin
         sym = one;
      end else if (d == 4'd4) begin
         sym = (k == 2'd0) ? one : five;
      end else if (d == 4'd9) begin
         sym = (k == 2'd0) ? one : ten;
      end else if (d >= 4'd5) begin
         sym = (k == 2'd0) ? five : one;
      end else begin
         sym = one;
      end
      return sym;
   endfunction

   function automatic logic [11:0] thou_val(input logic [2:0] t);
      logic [11:0] v;
      unique case (t)
         3'd1:    v = 12'd1000;
         3'd2:    v = 12'd2000;
         3'd3:    v = 12'd3000;
         3'd4:    v = 12'd4000;
         default: v = 12'd0;
      endcase
      return v;
   endfunction

   function automatic logic [9:0] hund_val(input logic [3:0] h);
      logic [9:0] v;
      unique case (h)
         4'd1:    v = 10'd100;
         4'd2:    v = 10'd200;
         4'd3:    v = 10'd300;
         4'd4:    v = 10'd400;
         4'd5:    v = 10'd500;
         4'd6:    v = 10'd600;
         4'd7:    v = 10'd700;
         4'd8:    v = 10'd800;
         4'd9:    v = 10'd900;
         default: v = 10'd0;
      endcase
      return v;
   endfunction

endpackage

>>> design/integer_to_roman_symbols_top.sv
// The front end splits a value into digits (F_THOU, F_HUND, F_TENS) and queues them;
// the back end emits one symbol per cycle while rsp_tready allows. The digit split of a
// new value overlaps with the emitter, so values are taken while symbols still go out.
// A value of zero produces no output transactions.
// Reset is synchronous, active high, and clears the sequencers, queue and output valid.
module integer_to_roman_symbols_top #(
   parameter int QueueDepth = i2r_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [2:0] symbol
   output logic        rsp_tlast    // last_symbol
);
   import i2r_pkg::*;

   q_wr_type   q_wr;
   q_rd_type   q_rd;
   logic       q_full;
   logic       q_pop;
   logic [2:0] symbol;

   i2r_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_value (req_tdata[11:0]),
      .q_wr     (q_wr),
      .q_full   (q_full)
   );

   i2r_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_full (q_full),
      .q_rd   (q_rd),
      .q_pop  (q_pop)
   );

   i2r_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_rd       (q_rd),
      .q_pop      (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_symbol (symbol),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {5'b00000, symbol};

endmodule

>>> design/i2r_front.sv
module i2r_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [11:0]       in_value,
   output i2r_pkg::q_wr_type q_wr,
   input  logic              q_full
);
   import i2r_pkg::*;

   front_state_type state_ff, state_in;
   logic [11:0] val_ff, val_in;
   logic [2:0]  thou_ff, thou_in;
   logic [9:0]  r1_ff, r1_in;
   logic [3:0]  hund_ff, hund_in;
   logic [6:0]  r2_ff, r2_in;

   logic [15:0] hund_prod;
   logic [13:0] tens_prod;
   logic [3:0]  tens_d;
   logic [3:0]  units_d;
   logic [6:0]  tens_x10;
   logic        is_zero;

   // r/100 = (r*41)>>12 for r < 1000; r/10 = (r*103)>>10 for r < 100
   assign hund_prod = 16'(r1_ff) * 16'd41;
   assign tens_prod = 14'(r2_ff) * 14'd103;
   assign tens_d    = tens_prod[13:10];
   assign tens_x10  = 7'({tens_d, 3'b000}) + 7'({tens_d, 1'b0});
   assign units_d   = 4'(r2_ff - tens_x10);
   assign is_zero   = (thou_ff == 3'd0) && (hund_ff == 4'd0) &&
                      (tens_d == 4'd0) && (units_d == 4'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      val_ff  <= val_in;
      thou_ff <= thou_in;
      r1_ff   <= r1_in;
      hund_ff <= hund_in;
      r2_ff   <= r2_in;
   end

   always_comb begin
      state_in  = state_ff;
      val_in    = val_ff;
      thou_in   = thou_ff;
      r1_in     = r1_ff;
      hund_in   = hund_ff;
      r2_in     = r2_ff;
      in_ready  = 1'b0;
      q_wr.valid          = 1'b0;
      q_wr.digits.thou    = thou_ff;
      q_wr.digits.hund    = hund_ff;
      q_wr.digits.tens    = tens_d;
      q_wr.digits.units   = units_d;
      unique case (state_ff)
         F_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               val_in   = in_value;
               state_in = F_THOU;
            end
         end
         F_THOU: begin
            priority if (val_ff >= 12'd4000) thou_in = 3'd4;
            else if (val_ff >= 12'd3000)     thou_in = 3'd3;
            else if (val_ff >= 12'd2000)     thou_in = 3'd2;
            else if (val_ff >= 12'd1000)     thou_in = 3'd1;
            else                             thou_in = 3'd0;
            r1_in    = 10'(val_ff - thou_val(thou_in));
            state_in = F_HUND;
         end
         F_HUND: begin
            hund_in  = hund_prod[15:12];
            r2_in    = 7'(r1_ff - hund_val(hund_in));
            state_in = F_TENS;
         end
         default: begin
            if (is_zero) begin
               state_in = F_IDLE;
            end else if (!q_full) begin
               q_wr.valid = 1'b1;
               state_in   = F_IDLE;
            end
         end
      endcase
   end

endmodule

>>> design/i2r_queue.sv
module i2r_queue #(
   parameter int QueueDepth = i2r_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  i2r_pkg::q_wr_type q_wr,
   output logic              q_full,
   output i2r_pkg::q_rd_type q_rd,
   input  logic              q_pop
);
   import i2r_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

   digits_type        mem_ff [QueueDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              push;
   logic              pop;

   assign q_full      = (count_ff == CntW'(QueueDepth));
   assign q_rd.valid  = (count_ff != '0);
   assign q_rd.digits = mem_ff[rd_ptr_ff];
   assign push        = q_wr.valid && !q_full;
   assign pop         = q_pop && q_rd.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= q_wr.digits;
      end
   end

endmodule

>>> design/i2r_back.sv
module i2r_back (
   input  logic              clock,
   input  logic              reset,
   input  i2r_pkg::q_rd_type q_rd,
   output logic              q_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [2:0]        out_symbol,
   output logic              out_last
);
   import i2r_pkg::*;

   logic        active_ff, active_in;
   logic [3:0]  dig_ff [4];
   logic [3:0]  dig_in [4];
   logic [1:0]  dec_ff, dec_in;
   logic [1:0]  k_ff, k_in;
   logic        vld_ff, vld_in;
   logic [2:0]  sym_ff, sym_in;
   logic        last_ff, last_in;

   logic [3:0]  ld_dig [4];
   logic [1:0]  ld_dec;
   logic [3:0]  cur_d;
   logic [2:0]  cur_len;
   logic        more_here;
   logic        nxt_found;
   logic [1:0]  nxt_dec;
   logic        step;

   assign ld_dig[0] = {1'b0, q_rd.digits.thou};
   assign ld_dig[1] = q_rd.digits.hund;
   assign ld_dig[2] = q_rd.digits.tens;
   assign ld_dig[3] = q_rd.digits.units;

   assign cur_d     = dig_ff[dec_ff];
   assign cur_len   = digit_len(dec_ff, cur_d);
   assign more_here = (3'({1'b0, k_ff}) + 3'd1) < cur_len;
   assign step      = active_ff && (!vld_ff || out_ready);
   assign q_pop     = q_rd.valid && !active_ff;

   always_comb begin
      ld_dec    = DEC_UNIT;
      nxt_found = 1'b0;
      nxt_dec   = DEC_UNIT;
      for (int i = 3; i >= 0; i--) begin
         if (ld_dig[i] != 4'd0) begin
            ld_dec = 2'(i);
         end
         if ((2'(i) > dec_ff) && (dig_ff[i] != 4'd0)) begin
            nxt_found = 1'b1;
            nxt_dec   = 2'(i);
         end
      end
   end

   always_comb begin
      active_in = active_ff;
      dig_in    = dig_ff;
      dec_in    = dec_ff;
      k_in      = k_ff;
      vld_in    = vld_ff;
      sym_in    = sym_ff;
      last_in   = last_ff;
      if (q_pop) begin
         active_in = 1'b1;
         dig_in    = ld_dig;
         dec_in    = ld_dec;
         k_in      = 2'd0;
      end
      if (step) begin
         vld_in  = 1'b1;
         sym_in  = digit_sym(dec_ff, cur_d, k_ff);
         last_in = !more_here && !nxt_found;
         if (more_here) begin
            k_in = k_ff + 2'd1;
         end else if (nxt_found) begin
            dec_in = nxt_dec;
            k_in   = 2'd0;
         end else begin
            active_in = 1'b0;
         end
      end else if (out_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         vld_ff    <= 1'b0;
      end else begin
         active_ff <= active_in;
         vld_ff    <= vld_in;
      end
      dig_ff  <= dig_in;
      dec_ff  <= dec_in;
      k_ff    <= k_in;
      sym_ff  <= sym_in;
      last_ff <= last_in;
   end

   assign out_valid  = vld_ff;
   assign out_symbol = sym_ff;
   assign out_last   = last_ff;

endmodule
